// ----- design/cts_pkg.sv -----
// ============================================================================
// Cosine series package
// Shared widths, fixed-point constants and the link word passed between the
// front end, the term cells and the result stage.
// ============================================================================
package cts_pkg;

   // Fraction bits of the working fixed-point format.
   localparam int WORK_FRAC = 48;
   // Fraction bits of the reduced angle (input angle times 256).
   localparam int RED_FRAC  = 32;

   // Port widths.
   localparam int ANGLE_W = 32;
   localparam int COS_W   = 32;

   // Angle reduction: magnitude of the angle scaled to Q.32, and the number of
   // restoring steps needed for a quotient below 32.
   localparam int RED_W     = 40;
   localparam int RED_STEPS = 5;
   localparam logic [RED_W-1:0] TWO_PI_Q32 = 40'd26986075409;

   // The reduced magnitude is below 2*pi in Q.32, so it fits in 35 bits.
   localparam int ROOT_W = 35;

   // Term magnitudes stay below 128, the square of the angle below 64, and
   // every partial sum below 512, all in Q.48.
   localparam int TERM_W = 55;
   localparam int X2_W   = 54;
   localparam int SUM_W  = 58;

   // Dividend width for the rounded division by a constant, and the width of
   // its reciprocal.
   localparam int NUM_W   = 62;
   localparam int RECIP_W = NUM_W + 1;

   // One word moving along the chain of term cells.
   typedef struct packed {
      logic                     valid;
      logic [TERM_W-1:0]        term;   // magnitude of the latest term
      logic [X2_W-1:0]          x2;     // square of the reduced angle
      logic signed [SUM_W-1:0]  sum;    // series sum without the latest term
   } cts_link_type;

endpackage

// ----- design/cosine_taylor_series_unit.sv -----
// ============================================================================
// Cosine Taylor series unit
// Cosine of a Q8.24 angle by reduction modulo 2*pi and a fixed number of
// Maclaurin terms, one term cell per term, giving a saturated Q2.30 result.
// ============================================================================
//
// Channel   Direction  Word                      Accepted when
// req_      in         angle, Q8.24, 32 bits     req_tvalid && req_tready
// rsp_      out        cosine, Q2.30, 32 bits    rsp_tvalid && rsp_tready
//
// One word is taken every cycle while the pipeline is not held; each term
// cell is a four-stage pipeline.
// Reset clears all valid bits and the output queue; no word survives.
// A full two-entry output queue with a word waiting in the last rounding
// stage holds the whole pipeline and drops req_tready for that cycle.
//
module cosine_taylor_series_unit
   import cts_pkg::*;
#(
   parameter int SERIES_TERMS  = 16,
   parameter int OUT_FRAC_BITS = 30
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [ANGLE_W-1:0] req_tdata,   // [31:0] angle
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [COS_W-1:0]   rsp_tdata    // [31:0] cosine
);

   logic         advance;
   cts_link_type chain [SERIES_TERMS+1];

   assign req_tready = advance;

   // Angle reduction and squaring.
   cts_front u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_tvalid),
      .angle    (req_tdata),
      .link_out (chain[0])
   );

   // One cell per series term.
   for (genvar k = 1; k <= SERIES_TERMS; k++) begin : g_cell
      cts_term_cell #(
         .CELL_INDEX (k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .link_in  (chain[k-1]),
         .link_out (chain[k])
      );
   end

   // Final sum, rounding, saturation and output queue.
   cts_result #(
      .SERIES_TERMS  (SERIES_TERMS),
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
   ) u_result (
      .clock      (clock),
      .reset      (reset),
      .link_in    (chain[SERIES_TERMS]),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- design/cts_front.sv -----
// ============================================================================
// Cosine series front end
// Reduces the angle magnitude modulo 2*pi with one restoring step per stage,
// then squares the reduced magnitude in split partial products.
// ============================================================================
module cts_front
   import cts_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  logic [ANGLE_W-1:0] angle,
   output cts_link_type       link_out
);

   // Square splitting and rounding.
   localparam int ROOT_LO  = 18;
   localparam int ROOT_HI  = ROOT_W - ROOT_LO;
   localparam int SQ_W     = 2 * ROOT_W;
   localparam int SQ_SHIFT = 2 * RED_FRAC - WORK_FRAC;

   // Magnitude of the incoming angle; the sign never matters for cosine.
   logic [ANGLE_W-1:0] abs_angle_in;
   assign abs_angle_in = angle[ANGLE_W-1] ? (~angle + 1'b1) : angle;

   logic [RED_STEPS:0] red_valid_ff;
   logic [RED_W-1:0]   red_rem_ff [RED_STEPS+1];

   // Valid bits of the reduction stages and the squaring stages.
   logic sq_valid_ff;
   logic x2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         red_valid_ff <= '0;
         sq_valid_ff  <= 1'b0;
         x2_valid_ff  <= 1'b0;
      end else if (advance) begin
         red_valid_ff <= {red_valid_ff[RED_STEPS-1:0], in_valid};
         sq_valid_ff  <= red_valid_ff[RED_STEPS];
         x2_valid_ff  <= sq_valid_ff;
      end
   end

   // Capture the angle magnitude in Q.32.
   always_ff @(posedge clock) begin
      if (advance) begin
         red_rem_ff[0] <= {abs_angle_in, {(RED_W - ANGLE_W){1'b0}}};
      end
   end

   // One restoring step per stage, largest multiple of 2*pi first.
   for (genvar j = 1; j <= RED_STEPS; j++) begin : g_red
      localparam logic [RED_W-1:0] STEP_MOD = TWO_PI_Q32 << (RED_STEPS - j);
      logic [RED_W-1:0] rem_in;
      assign rem_in = (red_rem_ff[j-1] >= STEP_MOD) ? (red_rem_ff[j-1] - STEP_MOD)
                                                    : red_rem_ff[j-1];
      always_ff @(posedge clock) begin
         if (advance) begin
            red_rem_ff[j] <= rem_in;
         end
      end
   end

   // Square of the reduced magnitude as three partial products.
   logic [ROOT_W-1:0]          root;
   logic [ROOT_HI-1:0]         root_hi;
   logic [ROOT_LO-1:0]         root_lo;
   logic [2*ROOT_HI-1:0]       sq_hh_in, sq_hh_ff;
   logic [ROOT_W-1:0]          sq_hl_in, sq_hl_ff;
   logic [2*ROOT_LO-1:0]       sq_ll_in, sq_ll_ff;

   assign root     = red_rem_ff[RED_STEPS][ROOT_W-1:0];
   assign root_hi  = root[ROOT_W-1:ROOT_LO];
   assign root_lo  = root[ROOT_LO-1:0];
   assign sq_hh_in = root_hi * root_hi;
   assign sq_hl_in = root_hi * root_lo;
   assign sq_ll_in = root_lo * root_lo;

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_hh_ff <= sq_hh_in;
         sq_hl_ff <= sq_hl_in;
         sq_ll_ff <= sq_ll_in;
      end
   end

   // Sum the partials and round the square to Q.48, half up.
   logic [SQ_W-1:0] sq_sum_in;
   logic [X2_W-1:0] x2_in, x2_ff;

   assign sq_sum_in = (SQ_W'(sq_hh_ff) << (2 * ROOT_LO))
                    + (SQ_W'(sq_hl_ff) << (ROOT_LO + 1))
                    + SQ_W'(sq_ll_ff)
                    + (SQ_W'(1) << (SQ_SHIFT - 1));
   assign x2_in = sq_sum_in[SQ_SHIFT +: X2_W];

   always_ff @(posedge clock) begin
      if (advance) begin
         x2_ff <= x2_in;
      end
   end

   // The series starts with a first term of one and an empty sum.
   assign link_out.valid = x2_valid_ff;
   assign link_out.term  = TERM_W'(1) << WORK_FRAC;
   assign link_out.x2    = x2_ff;
   assign link_out.sum   = '0;

   // The reduced angle always ends below 2*pi.
   a_reduced_range : assert property (@(posedge clock) disable iff (reset)
      red_valid_ff[RED_STEPS] |-> (red_rem_ff[RED_STEPS] < TWO_PI_Q32))
      else $error("reduced angle not below 2*pi");

endmodule

// ----- design/cts_term_cell.sv -----
// ============================================================================
// Cosine series term cell
// Computes the next term magnitude from the previous one: a rounded product
// with the squared angle, then a rounded division by (2k-1)(2k) done as a
// multiplication by a reciprocal. Also folds the previous term into the sum.
// ============================================================================
module cts_term_cell
   import cts_pkg::*;
#(
   parameter int CELL_INDEX = 1
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  cts_link_type link_in,
   output cts_link_type link_out
);

   // Divisor of this cell and its exact reciprocal for dividends below 2^NUM_W.
   localparam int DIVISOR     = (2 * CELL_INDEX - 1) * (2 * CELL_INDEX);
   localparam int DIV_LOG     = $clog2(DIVISOR);
   localparam int RECIP_SHIFT = NUM_W + DIV_LOG;
   localparam logic [127:0] RECIP_WIDE =
      ((128'd1 << RECIP_SHIFT) + 128'(DIVISOR) - 128'd1) / 128'(DIVISOR);
   localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_WIDE[RECIP_W-1:0];
   localparam logic [NUM_W-1:0]   HALF_DIV  = NUM_W'(DIVISOR / 2);

   // The incoming term is negative when its index is odd.
   localparam bit TERM_IN_NEG = ((CELL_INDEX - 1) % 2) == 1;

   // Operand splits for the two wide products.
   localparam int A_LO   = 28;
   localparam int A_HI   = TERM_W - A_LO;
   localparam int B_LO   = 27;
   localparam int B_HI   = X2_W - B_LO;
   localparam int N_LO   = 31;
   localparam int N_HI   = NUM_W - N_LO;
   localparam int R_LO   = 31;
   localparam int R_HI   = RECIP_W - R_LO;
   localparam int PROD_W = WORK_FRAC + NUM_W;
   localparam int QW     = (RECIP_SHIFT + TERM_W > NUM_W + RECIP_W) ?
                           (RECIP_SHIFT + TERM_W) : (NUM_W + RECIP_W);

   localparam logic [R_HI-1:0] RECIP_HI = RECIP_MUL[RECIP_W-1:R_LO];
   localparam logic [R_LO-1:0] RECIP_LO = RECIP_MUL[R_LO-1:0];

   // Stage valid bits.
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= link_in.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // Stage 1: partial products of term times square, and sum update.
   logic [A_HI-1:0]          a_hi;
   logic [A_LO-1:0]          a_lo;
   logic [B_HI-1:0]          b_hi;
   logic [B_LO-1:0]          b_lo;
   logic [A_HI+B_HI-1:0]     mul_hh_in, s1_hh_ff;
   logic [A_HI+B_LO-1:0]     mul_hl_in, s1_hl_ff;
   logic [A_LO+B_HI-1:0]     mul_lh_in, s1_lh_ff;
   logic [A_LO+B_LO-1:0]     mul_ll_in, s1_ll_ff;
   logic signed [SUM_W-1:0]  term_in_s;
   logic signed [SUM_W-1:0]  sum_acc_in, s1_sum_ff;
   logic [X2_W-1:0]          s1_x2_ff;

   assign a_hi      = link_in.term[TERM_W-1:A_LO];
   assign a_lo      = link_in.term[A_LO-1:0];
   assign b_hi      = link_in.x2[X2_W-1:B_LO];
   assign b_lo      = link_in.x2[B_LO-1:0];
   assign mul_hh_in = a_hi * b_hi;
   assign mul_hl_in = a_hi * b_lo;
   assign mul_lh_in = a_lo * b_hi;
   assign mul_ll_in = a_lo * b_lo;
   assign term_in_s = $signed(SUM_W'(link_in.term));
   assign sum_acc_in = TERM_IN_NEG ? (link_in.sum - term_in_s) : (link_in.sum + term_in_s);

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_hh_ff  <= mul_hh_in;
         s1_hl_ff  <= mul_hl_in;
         s1_lh_ff  <= mul_lh_in;
         s1_ll_ff  <= mul_ll_in;
         s1_sum_ff <= sum_acc_in;
         s1_x2_ff  <= link_in.x2;
      end
   end

   // Stage 2: round the product to Q.48 and add half the divisor in one sum.
   logic [PROD_W-1:0]        prod_in;
   logic [NUM_W-1:0]         num_in, s2_num_ff;
   logic signed [SUM_W-1:0]  s2_sum_ff;
   logic [X2_W-1:0]          s2_x2_ff;

   assign prod_in = (PROD_W'(s1_hh_ff) << (A_LO + B_LO))
                  + (PROD_W'(s1_hl_ff) << A_LO)
                  + (PROD_W'(s1_lh_ff) << B_LO)
                  + PROD_W'(s1_ll_ff)
                  + (PROD_W'(1) << (WORK_FRAC - 1))
                  + (PROD_W'(HALF_DIV) << WORK_FRAC);
   assign num_in = prod_in[WORK_FRAC +: NUM_W];

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_num_ff <= num_in;
         s2_sum_ff <= s1_sum_ff;
         s2_x2_ff  <= s1_x2_ff;
      end
   end

   // Stage 3: partial products of the dividend with the reciprocal.
   logic [N_HI-1:0]          n_hi;
   logic [N_LO-1:0]          n_lo;
   logic [N_HI+R_HI-1:0]     rec_hh_in, s3_hh_ff;
   logic [N_HI+R_LO-1:0]     rec_hl_in, s3_hl_ff;
   logic [N_LO+R_HI-1:0]     rec_lh_in, s3_lh_ff;
   logic [N_LO+R_LO-1:0]     rec_ll_in, s3_ll_ff;
   logic signed [SUM_W-1:0]  s3_sum_ff;
   logic [X2_W-1:0]          s3_x2_ff;

   assign n_hi      = s2_num_ff[NUM_W-1:N_LO];
   assign n_lo      = s2_num_ff[N_LO-1:0];
   assign rec_hh_in = n_hi * RECIP_HI;
   assign rec_hl_in = n_hi * RECIP_LO;
   assign rec_lh_in = n_lo * RECIP_HI;
   assign rec_ll_in = n_lo * RECIP_LO;

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_hh_ff  <= rec_hh_in;
         s3_hl_ff  <= rec_hl_in;
         s3_lh_ff  <= rec_lh_in;
         s3_ll_ff  <= rec_ll_in;
         s3_sum_ff <= s2_sum_ff;
         s3_x2_ff  <= s2_x2_ff;
      end
   end

   // Stage 4: sum the partials; the quotient sits above the reciprocal shift.
   logic [QW-1:0]            quo_in;
   logic [TERM_W-1:0]        term_in, s4_term_ff;
   logic signed [SUM_W-1:0]  s4_sum_ff;
   logic [X2_W-1:0]          s4_x2_ff;

   assign quo_in = (QW'(s3_hh_ff) << (N_LO + R_LO))
                 + (QW'(s3_hl_ff) << N_LO)
                 + (QW'(s3_lh_ff) << R_LO)
                 + QW'(s3_ll_ff);
   assign term_in = quo_in[RECIP_SHIFT +: TERM_W];

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_term_ff <= term_in;
         s4_sum_ff  <= s3_sum_ff;
         s4_x2_ff   <= s3_x2_ff;
      end
   end

   assign link_out.valid = s4_valid_ff;
   assign link_out.term  = s4_term_ff;
   assign link_out.x2    = s4_x2_ff;
   assign link_out.sum   = s4_sum_ff;

endmodule

// ----- design/cts_result.sv -----
// ============================================================================
// Cosine series result stage
// Adds the last term, rounds the sum to the output format with saturation
// to plus or minus one, and holds finished words in a two-entry queue.
// ============================================================================
module cts_result
   import cts_pkg::*;
#(
   parameter int SERIES_TERMS  = 16,
   parameter int OUT_FRAC_BITS = 30
)
(
   input  logic             clock,
   input  logic             reset,
   input  cts_link_type     link_in,
   output logic             advance,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [COS_W-1:0] rsp_tdata
);

   localparam bit LAST_NEG = (SERIES_TERMS % 2) == 1;
   localparam int R_SHIFT  = WORK_FRAC - OUT_FRAC_BITS;
   localparam int RND_W    = SUM_W - R_SHIFT;
   localparam int QS_W     = OUT_FRAC_BITS + 1;
   localparam logic [RND_W-1:0] SAT_LIM = RND_W'(1) << OUT_FRAC_BITS;
   localparam logic signed [COS_W-1:0] COS_MAX = COS_W'(1) << OUT_FRAC_BITS;
   localparam logic signed [COS_W-1:0] COS_MIN = -COS_MAX;

   logic f1_valid_ff, f2_valid_ff, f3_valid_ff;
   logic [1:0] count_ff;
   logic push, pop;

   // The pipeline holds only when a finished word has nowhere to go.
   assign advance = !(f3_valid_ff && (count_ff == 2'd2));
   assign push    = advance && f3_valid_ff;
   assign pop     = (count_ff != 2'd0) && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
      end else if (advance) begin
         f1_valid_ff <= link_in.valid;
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
      end
   end

   // Fold in the last term, take the magnitude, then round and saturate.
   logic signed [SUM_W-1:0] last_term_s;
   logic signed [SUM_W-1:0] sum_in, f1_sum_ff;
   logic [SUM_W-1:0]        mag_in, f2_mag_ff;
   logic                    f2_neg_ff, f3_neg_ff;
   logic [SUM_W-1:0]        round_sum_in;
   logic [RND_W-1:0]        rounded_in;
   logic [QS_W-1:0]         quant_in, f3_q_ff;

   assign last_term_s  = $signed(SUM_W'(link_in.term));
   assign sum_in       = LAST_NEG ? (link_in.sum - last_term_s) : (link_in.sum + last_term_s);
   assign mag_in       = f1_sum_ff[SUM_W-1] ? SUM_W'(-f1_sum_ff) : SUM_W'(f1_sum_ff);
   assign round_sum_in = f2_mag_ff + (SUM_W'(1) << (R_SHIFT - 1));
   assign rounded_in   = round_sum_in[SUM_W-1:R_SHIFT];
   assign quant_in     = (rounded_in > SAT_LIM) ? SAT_LIM[QS_W-1:0] : rounded_in[QS_W-1:0];

   always_ff @(posedge clock) begin
      if (advance) begin
         f1_sum_ff <= sum_in;
         f2_mag_ff <= mag_in;
         f2_neg_ff <= f1_sum_ff[SUM_W-1];
         f3_q_ff   <= quant_in;
         f3_neg_ff <= f2_neg_ff;
      end
   end

   // Two-entry output queue.
   logic [COS_W-1:0] cos_in;
   logic [COS_W-1:0] queue_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;

   assign cos_in = f3_neg_ff ? (COS_W'(0) - COS_W'(f3_q_ff)) : COS_W'(f3_q_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cos_in;
      end
   end

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = queue_ff[rd_ptr_ff];

   // The queue never holds more than two words.
   a_queue_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("output queue overflow");

   // A word blocked by a full queue waits unchanged in the last stage.
   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      (f3_valid_ff && (count_ff == 2'd2)) |=>
         (f3_valid_ff && $stable(f3_q_ff) && $stable(f3_neg_ff)))
      else $error("stalled word lost or changed");

   // Every delivered cosine lies within plus or minus one.
   a_cos_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (($signed(rsp_tdata) <= COS_MAX) && ($signed(rsp_tdata) >= COS_MIN)))
      else $error("cosine beyond plus or minus one");

endmodule

// ----- tb/sv/cosine_series_checker.sv -----
`timescale 1ns / 100ps
// ============================================================================
// Cosine series checker
// Watches the angle and cosine channels of the cosine Taylor series unit.
// For every accepted angle word it computes the expected Q2.30 cosine with
// its own fixed-point series. It then compares each accepted cosine word
// with the oldest expected value.
// ============================================================================
module cosine_series_checker #(
   parameter int SERIES_TERMS  = 16,
   parameter int OUT_FRAC_BITS = 30
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,    // [31:0] angle
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,    // [31:0] cosine
   output int          pending,
   output int          errors
);

   // Working format is Q.48; the angle is reduced in Q.32.
   localparam int     FRAC_BITS  = 48;
   localparam longint TWO_PI_FIX = 64'sd26986075409;

   typedef struct {
      logic [31:0] angle;
      logic [31:0] cosine;
   } cosine_expect_type;

   cosine_expect_type cosine_q[$];

   initial begin
      pending = 0;
      errors  = 0;
   end

   function automatic longint unsigned magnitude(input longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   // Signed Q.48 product, rounded by magnitude with ties away from zero.
   function automatic longint q48_mul(input longint a, input longint b);
      logic [127:0] prod;
      longint       mag_res;
      prod = {64'd0, magnitude(a)} * {64'd0, magnitude(b)} + (128'd1 << (FRAC_BITS - 1));
      mag_res = longint'(prod[FRAC_BITS +: 64]);
      return ((a < 0) != (b < 0)) ? -mag_res : mag_res;
   endfunction

   // Signed division by a positive constant, rounded by magnitude.
   function automatic longint div_round(input longint a, input longint unsigned d);
      longint unsigned q;
      q = (magnitude(a) + d / 2) / d;
      return (a < 0) ? -longint'(q) : longint'(q);
   endfunction

   // Expected cosine word for one angle word.
   function automatic logic [31:0] cosine_of(input logic [31:0] angle);
      longint          reduced;
      longint          x2;
      longint          term;
      longint          sum;
      longint unsigned rounded;
      longint unsigned limit;
      int              shift;
      longint          signed_out;
      reduced = (longint'(signed'(angle)) * 256) % TWO_PI_FIX;
      x2      = q48_mul(reduced * 65536, reduced * 65536);
      term    = 64'sd1 <<< FRAC_BITS;
      sum     = term;
      for (int k = 1; k <= SERIES_TERMS; k++) begin
         term = -div_round(q48_mul(term, x2), longint'((2 * k - 1) * (2 * k)));
         sum += term;
      end
      shift   = FRAC_BITS - OUT_FRAC_BITS;
      rounded = (magnitude(sum) + (64'd1 << (shift - 1))) >> shift;
      limit   = 64'd1 << OUT_FRAC_BITS;
      if (rounded > limit) begin
         rounded = limit;
      end
      signed_out = (sum < 0) ? -longint'(rounded) : longint'(rounded);
      return signed_out[31:0];
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t cosine check: %s", $realtime, what);
      errors++;
   endtask

   // Results are matched first, then the new angle is queued, so a word that
   // arrives with nothing waiting is never paired with this cycle's angle.
   always @(posedge clock) begin
      cosine_expect_type exp_word;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (cosine_q.size() == 0) begin
               report_mismatch($sformatf("unexpected cosine word %h", rsp_tdata));
            end else begin
               exp_word = cosine_q.pop_front();
               if (rsp_tdata !== exp_word.cosine) begin
                  report_mismatch($sformatf("angle %h: cosine %h, expected %h",
                                            exp_word.angle, rsp_tdata, exp_word.cosine));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            exp_word.angle  = req_tdata;
            exp_word.cosine = cosine_of(req_tdata);
            cosine_q.push_back(exp_word);
         end
      end
      pending <= cosine_q.size();
   end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// Cosine Taylor series unit testbench
// Drives angle words in random bursts while the result side stalls in
// changing patterns. A directed set covers the field extremes and angles near
// multiples of pi/2 and 2*pi. After it, random angles run over the full range,
// within one turn and close to the reduction boundaries.
// ============================================================================
module tb;

   localparam int SERIES_TERMS  = 16;
   localparam int OUT_FRAC_BITS = 30;
   localparam int PIPE_LATENCY  = 12 + 4 * SERIES_TERMS;
   localparam int RANDOM_WORDS  = 1830;

   // Q8.24 angles close to the reduction boundaries.
   localparam int TWO_PI_Q24  = 105414357;
   localparam int HALF_PI_Q24 = 26353589;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_RARELY,
      READY_EVERY_THIRD
   } sink_mode_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;    // [31:0] angle
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // [31:0] cosine
   int          pending;
   int          errors;

   sink_mode_type sink_mode = READY_ALWAYS;
   int          sink_left  = 0;
   int          burst_left = 0;

   always #4 clock = ~clock;

   cosine_taylor_series_unit #(
      .SERIES_TERMS  (SERIES_TERMS),
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   cosine_series_checker #(
      .SERIES_TERMS  (SERIES_TERMS),
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .pending    (pending),
      .errors     (errors)
   );

   // The result side switches at random between stall patterns.
   always @(posedge clock) begin
      if (sink_left == 0) begin
         sink_mode <= sink_mode_type'($urandom_range(0, 3));
         sink_left <= $urandom_range(20, 300);
      end else begin
         sink_left <= sink_left - 1;
      end
      case (sink_mode)
         READY_ALWAYS: begin
            rsp_tready <= 1'b1;
         end
         READY_MOSTLY: begin
            rsp_tready <= ($urandom_range(0, 9) < 7);
         end
         READY_RARELY: begin
            rsp_tready <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            rsp_tready <= (sink_left % 3 == 0);
         end
      endcase
   end

   // Sends one angle word; a new burst may start with an idle gap.
   task automatic send_angle(input logic [31:0] angle);
      int gap;
      if (burst_left == 0) begin
         case ($urandom_range(0, 9)) inside
            [0:3]:   gap = 0;
            9:       gap = $urandom_range(10, 40);
            default: gap = $urandom_range(1, 4);
         endcase
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 40);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= angle;
      do @(posedge clock); while (!req_tready);
   endtask

   // Holds off the sender until every cosine has come back.
   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] random_angle();
      int base;
      case ($urandom_range(0, 19)) inside
         [0:5]: begin
            return $urandom();
         end
         [6:12]: begin
            base = int'($urandom_range(0, 2 * TWO_PI_Q24 + 2)) - (TWO_PI_Q24 + 1);
            return base;
         end
         [13:15]: begin
            base = (int'($urandom_range(0, 40)) - 20) * TWO_PI_Q24;
            return base + int'($urandom_range(0, 128)) - 64;
         end
         [16:18]: begin
            base = (int'($urandom_range(0, 162)) - 81) * HALF_PI_Q24;
            return base + int'($urandom_range(0, 512)) - 256;
         end
         default: begin
            return int'($urandom_range(0, 8190)) - 4095;
         end
      endcase
   endfunction

   initial begin
      logic [31:0] directed_angles[$];
      directed_angles = '{
         32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
         32'h0100_0000, 32'hFF00_0000, 32'h5555_5555, 32'hAAAA_AAAA,
         HALF_PI_Q24, -HALF_PI_Q24, 2 * HALF_PI_Q24, -2 * HALF_PI_Q24,
         3 * HALF_PI_Q24, TWO_PI_Q24 - 1, TWO_PI_Q24, -TWO_PI_Q24,
         TWO_PI_Q24 + 1, -(TWO_PI_Q24 + 1), 20 * TWO_PI_Q24, -20 * TWO_PI_Q24,
         20 * TWO_PI_Q24 + 1
      };
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed angles, then a full drain before the random part.
      foreach (directed_angles[i]) begin
         send_angle(directed_angles[i]);
      end
      drain();

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == RANDOM_WORDS / 2) begin
            drain();
         end
         send_angle(random_angle());
      end

      drain();
      repeat (PIPE_LATENCY + 16) @(posedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin
      #5000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
